// ===== design/vsil_pkg.sv =====
// shared types and constants for the view-space in-line test pipeline
// no dependencies; imported by every vsil module and the top level

package vsil_pkg;

    // apb address width: five 32-bit registers at byte offsets 0..16
    localparam int unsigned ADDR_W = 5;

    localparam logic [14:0] HALF_WIDTH_RESET = 15'd80;

    typedef enum logic [2:0] {
        REG_VIEWER_X    = 3'd0,
        REG_VIEWER_Z    = 3'd1,
        REG_VIEW_SINE   = 3'd2,
        REG_VIEW_COSINE = 3'd3,
        REG_HALF_WIDTH  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [15:0] viewer_x;
        logic signed [15:0] viewer_z;
        logic signed [15:0] view_sine;
        logic signed [15:0] view_cosine;
        logic [14:0]        half_width;
    } t_view_cfg;

    // sideband that travels with each item down the pipe
    typedef struct packed {
        logic valid;
        logic absent;
        logic last;
    } t_tag;

endpackage

// ===== design/vsil_regs.sv =====
// apb configuration registers for the view-space in-line test
// depends on vsil_pkg

module vsil_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vsil_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output vsil_pkg::t_view_cfg         o_cfg
);
    import vsil_pkg::*;

    t_view_cfg r_cfg;
    t_reg_idx  idx;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.viewer_x    <= '0;
            r_cfg.viewer_z    <= '0;
            r_cfg.view_sine   <= '0;
            r_cfg.view_cosine <= '0;
            r_cfg.half_width  <= HALF_WIDTH_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_VIEWER_X:    r_cfg.viewer_x    <= pwdata[15:0];
                REG_VIEWER_Z:    r_cfg.viewer_z    <= pwdata[15:0];
                REG_VIEW_SINE:   r_cfg.view_sine   <= pwdata[15:0];
                REG_VIEW_COSINE: r_cfg.view_cosine <= pwdata[15:0];
                REG_HALF_WIDTH:  r_cfg.half_width  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_VIEWER_X:    prdata = {16'd0, r_cfg.viewer_x};
            REG_VIEWER_Z:    prdata = {16'd0, r_cfg.viewer_z};
            REG_VIEW_SINE:   prdata = {16'd0, r_cfg.view_sine};
            REG_VIEW_COSINE: prdata = {16'd0, r_cfg.view_cosine};
            REG_HALF_WIDTH:  prdata = {17'd0, r_cfg.half_width};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/vsil_delta.sv =====
// stage 1: viewer-relative offsets with 16-bit wrap, tag capture
// depends on vsil_pkg

module vsil_delta (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic                i_is_aux,
    input  logic signed [15:0]  i_zone_id,
    input  logic signed [15:0]  i_point_x,
    input  logic signed [15:0]  i_point_z,
    input  logic                i_is_last,
    input  logic signed [15:0]  i_viewer_x,
    input  logic signed [15:0]  i_viewer_z,
    output vsil_pkg::t_tag      o_tag,
    output logic signed [15:0]  o_dx,
    output logic signed [15:0]  o_dz
);
    import vsil_pkg::*;

    t_tag               r_tag;
    logic signed [15:0] r_dx;
    logic signed [15:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            // auxiliary slots give no result and drop out here
            r_tag.valid <= i_take && !i_is_aux;
        end
        r_tag.absent <= i_zone_id[15];
        r_tag.last   <= i_is_last;
        r_dx         <= i_point_x - i_viewer_x;
        r_dz         <= i_point_z - i_viewer_z;
    end

    assign o_tag = r_tag;
    assign o_dx  = r_dx;
    assign o_dz  = r_dz;

endmodule

// ===== design/vsil_mult.sv =====
// stage 2: the four 16x16 signed rotation products
// depends on vsil_pkg

module vsil_mult (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vsil_pkg::t_tag      i_tag,
    input  logic signed [15:0]  i_dx,
    input  logic signed [15:0]  i_dz,
    input  logic signed [15:0]  i_sine,
    input  logic signed [15:0]  i_cosine,
    output vsil_pkg::t_tag      o_tag,
    output logic signed [31:0]  o_dx_c,
    output logic signed [31:0]  o_dz_s,
    output logic signed [31:0]  o_dx_s,
    output logic signed [31:0]  o_dz_c
);
    import vsil_pkg::*;

    t_tag               r_tag;
    logic signed [31:0] r_dx_c;
    logic signed [31:0] r_dz_s;
    logic signed [31:0] r_dx_s;
    logic signed [31:0] r_dz_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
        r_tag.absent <= i_tag.absent;
        r_tag.last   <= i_tag.last;
        r_dx_c       <= i_dx * i_cosine;
        r_dz_s       <= i_dz * i_sine;
        r_dx_s       <= i_dx * i_sine;
        r_dz_c       <= i_dz * i_cosine;
    end

    assign o_tag  = r_tag;
    assign o_dx_c = r_dx_c;
    assign o_dz_s = r_dz_s;
    assign o_dx_s = r_dx_s;
    assign o_dz_c = r_dz_c;

endmodule

// ===== design/vsil_accum.sv =====
// stage 3: horizontal and depth sums, scaled and wrapped to 32 bits
// depends on vsil_pkg

module vsil_accum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vsil_pkg::t_tag      i_tag,
    input  logic signed [31:0]  i_dx_c,
    input  logic signed [31:0]  i_dz_s,
    input  logic signed [31:0]  i_dx_s,
    input  logic signed [31:0]  i_dz_c,
    output vsil_pkg::t_tag      o_tag,
    output logic [31:0]         o_h,
    output logic signed [15:0]  o_dw
);
    import vsil_pkg::*;

    t_tag               r_tag;
    logic [31:0]        r_h;
    logic signed [15:0] r_dw;
    logic [31:0]        h_diff;
    logic [31:0]        d_sum;

    assign h_diff = i_dx_c - i_dz_s;
    assign d_sum  = i_dx_s + i_dz_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag.valid <= 1'b0;
        end else begin
            r_tag.valid <= i_tag.valid;
        end
        r_tag.absent <= i_tag.absent;
        r_tag.last   <= i_tag.last;
        r_h          <= {h_diff[30:0], 1'b0};
        // high word of 4*sum
        r_dw         <= d_sum[29:14];
    end

    assign o_tag = r_tag;
    assign o_h   = r_h;
    assign o_dw  = r_dw;

endmodule

// ===== design/vsil_cull.sv =====
// stage 4: fold h positive, halve its high word, test ahead and width
// depends on vsil_pkg; drives the registered result

module vsil_cull (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vsil_pkg::t_tag      i_tag,
    input  logic [31:0]         i_h,
    input  logic signed [15:0]  i_dw,
    input  logic [14:0]         i_half_width,
    output logic                o_valid,
    output logic                o_in_line,
    output logic [15:0]         o_distance,
    output logic                o_last
);
    import vsil_pkg::*;

    logic               r_valid;
    logic               r_in_line;
    logic [15:0]        r_distance;
    logic               r_last;
    logic [31:0]        h_abs;
    logic signed [15:0] hw;
    logic signed [15:0] half;
    logic               width_ok;
    logic               ahead;

    // zero and negative both negate; most negative wraps to itself
    assign h_abs    = (i_h == 32'd0 || i_h[31]) ? (32'd0 - i_h) : i_h;
    assign hw       = h_abs[31:16];
    assign half     = hw >>> 1;
    assign width_ok = $signed({half[15], half}) <= $signed({2'b00, i_half_width});
    assign ahead    = !i_dw[15] && (i_dw != 16'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_tag.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_line  <= !i_tag.absent && ahead && width_ok;
        r_distance <= i_tag.absent ? 16'd0 : i_dw;
        r_last     <= i_tag.last;
    end

    assign o_valid    = r_valid;
    assign o_in_line  = r_in_line;
    assign o_distance = r_distance;
    assign o_last     = r_last;

endmodule

// ===== design/view_space_in_line_test.sv =====
// top level of the view-space in-line test: apb registers and four-stage pipe
// depends on vsil_pkg, vsil_regs, vsil_delta, vsil_mult, vsil_accum, vsil_cull

// Takes one object item per clock for as long as start is held; busy never
// rises, because every stage advances each cycle and nothing waits on the
// output. Each non-auxiliary item passes through the four register stages,
// offset subtract, the four 16x16 products, the two 32-bit sums, and the
// fold, halve and compare that feed the output register, and comes out on
// the cycle o_valid is high, in the same order as it went in; auxiliary
// items leave no result. The receiver cannot stall the pipe, so it must take
// each result in the cycle it is shown. The viewer registers are read live,
// so write them only while no item is in flight.

module view_space_in_line_test (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // item command port
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_is_aux,
    input  logic signed [15:0]          i_zone_id,
    input  logic signed [15:0]          i_point_x,
    input  logic signed [15:0]          i_point_z,
    input  logic                        i_is_last,
    // result port
    output logic                        o_valid,
    output logic                        o_in_line,
    output logic [15:0]                 o_distance,
    output logic                        o_last,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vsil_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import vsil_pkg::*;

    t_view_cfg          cfg;
    t_tag               s1_tag;
    t_tag               s2_tag;
    t_tag               s3_tag;
    logic signed [15:0] s1_dx;
    logic signed [15:0] s1_dz;
    logic signed [31:0] s2_dx_c;
    logic signed [31:0] s2_dz_s;
    logic signed [31:0] s2_dx_s;
    logic signed [31:0] s2_dz_c;
    logic [31:0]        s3_h;
    logic signed [15:0] s3_dw;

    // fully pipelined, an item enters every cycle
    assign busy = 1'b0;

    vsil_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage 1: offsets from the viewer
    vsil_delta u_delta (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (start && !busy),
        .i_is_aux   (i_is_aux),
        .i_zone_id  (i_zone_id),
        .i_point_x  (i_point_x),
        .i_point_z  (i_point_z),
        .i_is_last  (i_is_last),
        .i_viewer_x (cfg.viewer_x),
        .i_viewer_z (cfg.viewer_z),
        .o_tag      (s1_tag),
        .o_dx       (s1_dx),
        .o_dz       (s1_dz)
    );

    // stage 2: rotation products
    vsil_mult u_mult (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (s1_tag),
        .i_dx     (s1_dx),
        .i_dz     (s1_dz),
        .i_sine   (cfg.view_sine),
        .i_cosine (cfg.view_cosine),
        .o_tag    (s2_tag),
        .o_dx_c   (s2_dx_c),
        .o_dz_s   (s2_dz_s),
        .o_dx_s   (s2_dx_s),
        .o_dz_c   (s2_dz_c)
    );

    // stage 3: horizontal term and depth word
    vsil_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (s2_tag),
        .i_dx_c  (s2_dx_c),
        .i_dz_s  (s2_dz_s),
        .i_dx_s  (s2_dx_s),
        .i_dz_c  (s2_dz_c),
        .o_tag   (s3_tag),
        .o_h     (s3_h),
        .o_dw    (s3_dw)
    );

    // stage 4: in-line decision into the output register
    vsil_cull u_cull (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (s3_tag),
        .i_h          (s3_h),
        .i_dw         (s3_dw),
        .i_half_width (cfg.half_width),
        .o_valid      (o_valid),
        .o_in_line    (o_in_line),
        .o_distance   (o_distance),
        .o_last       (o_last)
    );

endmodule

// ===== test/tb_top.sv =====
// testbench for view_space_in_line_test: directed table then random object stream
// checks every result against an in-bench view-space predictor or a typed table row; needs vsil_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;
    import vsil_pkg::*;

    // stimulus sizing and run limits
    localparam int unsigned RAND_ITEMS  = 1660;    // non-auxiliary random items
    localparam int unsigned PIPE_FLUSH  = 8;       // cycles after last result, pipe is 4 deep
    localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog limit on the whole run
    localparam int unsigned NUM_REGS    = 5;       // register indexes 5..7 are unmapped
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DIR_ROWS    = 22;

    // one result as the block presents it
    typedef struct packed {
        logic        in_line;
        logic [15:0] distance;
        logic        last;
    } t_cull_result;

    // one row of the directed table; typed rows carry their own expected result
    typedef struct packed {
        logic [1:0]  sel;      // which view setting must be loaded first
        logic        aux;
        logic [15:0] zone;
        logic [15:0] px;
        logic [15:0] pz;
        logic        last;
        logic        typed;
        logic        in_line;
        logic [15:0] exp_dist;
    } t_dir_row;

    // clock, reset and block ports
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_is_aux;
    logic signed [15:0]  i_zone_id;
    logic signed [15:0]  i_point_x;
    logic signed [15:0]  i_point_z;
    logic                i_is_last;
    logic                o_valid;
    logic                o_in_line;
    logic [15:0]         o_distance;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    // mirror of the view registers, updated as each write lands
    t_view_cfg           view_regs;
    // predicted results in item order, oldest at the front
    t_cull_result        cull_results_due [$];

    int unsigned         cycle_count     = 0;
    int unsigned         mismatch_count  = 0;
    int unsigned         items_sent      = 0;
    int unsigned         aux_sent        = 0;
    int unsigned         absent_sent     = 0;
    int unsigned         results_checked = 0;
    int unsigned         in_line_seen    = 0;
    int unsigned         settings_loaded = 0;

    // directed view settings: reset values, straight ahead, all extremes,
    // and one that drives h to its most negative value
    t_view_cfg dir_cfgs [4] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'd80},
        '{16'h0000, 16'h0000, 16'h0000, 16'h4000, 15'd80},
        '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 15'h7FFF},
        '{16'h0000, 16'h0000, 16'hFFFF, 16'h8000, 15'd0}
    };

    // directed table
    // sel, aux, zone, x, z, last, typed, in_line, distance
    t_dir_row dir_rows [DIR_ROWS] = '{
        // reset setting: sine and cosine are zero, so every present object
        // lands on the viewer with depth zero and is never in line
        '{2'd0, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{2'd0, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{2'd0, 1'b0, 16'h0000, 16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000},
        // auxiliary slot with last set: no result at all
        '{2'd0, 1'b1, 16'h0000, 16'h1234, 16'h4321, 1'b1, 1'b1, 1'b0, 16'h0000},
        // absent object, most negative zone
        '{2'd0, 1'b0, 16'h8000, 16'h0100, 16'h0100, 1'b0, 1'b1, 1'b0, 16'h0000},
        // facing +z: on axis, right at the half-width, just past it, behind
        '{2'd1, 1'b0, 16'h0001, 16'h0000, 16'h0064, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd1, 1'b0, 16'h0001, 16'h0140, 16'h0064, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd1, 1'b0, 16'h0001, 16'hFEBC, 16'h0064, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd1, 1'b0, 16'h0001, 16'h0000, 16'hFF9C, 1'b0, 1'b0, 1'b0, 16'h0000},
        // absent with zone -1
        '{2'd1, 1'b0, 16'hFFFF, 16'h0000, 16'h0064, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{2'd1, 1'b1, 16'h8000, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b0, 16'h0000},
        // extreme registers against extreme points, offsets wrap
        '{2'd2, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd2, 1'b0, 16'h0000, 16'h8000, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd2, 1'b0, 16'h0001, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{2'd2, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd2, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        // most negative h: negation wraps to itself, width test still passes
        '{2'd3, 1'b0, 16'h0000, 16'h8000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd3, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd3, 1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{2'd3, 1'b0, 16'h0002, 16'h0000, 16'h0001, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{2'd3, 1'b1, 16'h7FFF, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 16'h0000},
        '{2'd3, 1'b0, 16'h0003, 16'h8001, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000}
    };

    view_space_in_line_test i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_is_aux   (i_is_aux),
        .i_zone_id  (i_zone_id),
        .i_point_x  (i_point_x),
        .i_point_z  (i_point_z),
        .i_is_last  (i_is_last),
        .o_valid    (o_valid),
        .o_in_line  (o_in_line),
        .o_distance (o_distance),
        .o_last     (o_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // view-space transform and cull of one item; returns 0 when no result
    function automatic bit predict_cull(input t_view_cfg cfg, input logic aux,
                                        input logic [15:0] zone, input logic [15:0] px,
                                        input logic [15:0] pz, input logic last,
                                        output t_cull_result res);
        logic [15:0]        dx, dz;
        logic signed [15:0] hw, dw;
        logic signed [31:0] dx32, dz32, s32, c32, h, d;
        int                 half, width;
        res      = '0;
        res.last = last;
        if (aux)
            return 0;
        // absent object: in_line and distance both zero
        if (zone[15])
            return 1;
        // offsets wrap at 16 bits, then sign-extend everything to 32
        dx    = px - cfg.viewer_x;
        dz    = pz - cfg.viewer_z;
        dx32  = {{16{dx[15]}}, dx};
        dz32  = {{16{dz[15]}}, dz};
        s32   = {{16{cfg.view_sine[15]}}, cfg.view_sine};
        c32   = {{16{cfg.view_cosine[15]}}, cfg.view_cosine};
        // horizontal term folded to non-negative, except 0x80000000 stays put
        h     = (dx32 * c32 - dz32 * s32) << 1;
        if (h == 32'sd0 || h[31])
            h = -h;
        hw    = h[31:16];
        half  = int'(hw) >>> 1;
        // depth word
        d     = (dx32 * s32 + dz32 * c32) << 2;
        dw    = d[31:16];
        width = int'(cfg.half_width);
        res.in_line  = (dw > 16'sd0) && (half <= width);
        res.distance = dw;
        return 1;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // apb write: setup cycle, access cycle, done on the edge with pready high;
    // then idles the bus through the next edge so the next caller starts on a fresh edge
    task automatic apb_write(input int unsigned idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_VIEWER_X:    view_regs.viewer_x    = data[15:0];
            REG_VIEWER_Z:    view_regs.viewer_z    = data[15:0];
            REG_VIEW_SINE:   view_regs.view_sine   = data[15:0];
            REG_VIEW_COSINE: view_regs.view_cosine = data[15:0];
            REG_HALF_WIDTH:  view_regs.half_width  = data[14:0];
            default: ;       // unmapped index, write is dropped
        endcase
        @(posedge i_clk);
    endtask

    // load a full view setting; upper data bits carry junk that must be masked,
    // and a junk write to an unmapped index must change nothing
    task automatic load_view(input t_view_cfg cfg);
        apb_write(REG_VIEWER_X,    {16'($urandom), cfg.viewer_x});
        apb_write(REG_VIEWER_Z,    {16'($urandom), cfg.viewer_z});
        apb_write(REG_VIEW_SINE,   {16'($urandom), cfg.view_sine});
        apb_write(REG_VIEW_COSINE, {16'($urandom), cfg.view_cosine});
        apb_write(REG_HALF_WIDTH,  {17'($urandom), cfg.half_width});
        apb_write(NUM_REGS + $urandom_range(0, 2), $urandom);
        settings_loaded++;
    endtask

    // wait for the pipe to empty; aux items leave nothing to wait on, so
    // also wait out PIPE_FLUSH before touching the registers
    task automatic wait_drained();
        while (cull_results_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    // present one item after a gap and hold it until taken; start stays high
    // into the next item when that one has no gap
    task automatic send_item(input logic aux, input logic [15:0] zone,
                             input logic [15:0] px, input logic [15:0] pz,
                             input logic last, input int unsigned gap,
                             input bit typed, input t_cull_result typed_res);
        t_cull_result res;
        bit           has_res;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_is_aux  <= aux;
        i_zone_id <= zone;
        i_point_x <= px;
        i_point_z <= pz;
        i_is_last <= last;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        // taken at this edge
        has_res = predict_cull(view_regs, aux, zone, px, pz, last, res);
        if (has_res)
            cull_results_due.push_back(typed ? typed_res : res);
        items_sent++;
        if (aux)
            aux_sent++;
        else if (zone[15])
            absent_sent++;
    endtask

    // random register word, biased toward the extremes
    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_cull_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (cull_results_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result in_line=%0b distance=%h last=%0b",
                                        o_in_line, o_distance, o_last));
            end else begin
                want = cull_results_due.pop_front();
                if (o_in_line !== want.in_line || o_distance !== want.distance ||
                    o_last !== want.last)
                    flag_mismatch($sformatf({"in_line exp %0b got %0b, distance exp %h ",
                                             "got %h, last exp %0b got %0b"},
                                            want.in_line, o_in_line, want.distance,
                                            o_distance, want.last, o_last));
                results_checked++;
                if (want.in_line)
                    in_line_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, cull_results_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_view_cfg    cfg;
        t_cull_result typed_res;
        logic [1:0]   cur_sel;
        logic         aux, last;
        logic [15:0]  zone, px, pz;
        int unsigned  rand_nonaux, phase_len;
        bit           quiet;
        int           off_x, off_z;

        // every input known from time zero, reset held low before the run
        i_rst_n   = 1'b0;
        start     = 1'b0;
        i_is_aux  = 1'b0;
        i_zone_id = '0;
        i_point_x = '0;
        i_point_z = '0;
        i_is_last = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        view_regs = dir_cfgs[0];
        cur_sel   = 2'd0;
        rand_nonaux = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reloading the view whenever a row asks for another
        foreach (dir_rows[r]) begin
            if (dir_rows[r].sel != cur_sel) begin
                start <= 1'b0;
                wait_drained();
                load_view(dir_cfgs[dir_rows[r].sel]);
                cur_sel = dir_rows[r].sel;
            end
            typed_res = '{dir_rows[r].in_line, dir_rows[r].exp_dist, dir_rows[r].last};
            send_item(dir_rows[r].aux, dir_rows[r].zone, dir_rows[r].px, dir_rows[r].pz,
                      dir_rows[r].last, $urandom_range(0, 7), dir_rows[r].typed, typed_res);
        end

        // random phases, each with a fresh view setting loaded while idle
        while (rand_nonaux < RAND_ITEMS) begin
            start <= 1'b0;
            wait_drained();
            cfg.viewer_x    = pick_word();
            cfg.viewer_z    = pick_word();
            cfg.view_sine   = pick_word();
            cfg.view_cosine = pick_word();
            case ($urandom_range(0, 4))
                0:       cfg.half_width = 15'd0;
                1:       cfg.half_width = 15'h7FFF;
                2:       cfg.half_width = 15'($urandom);
                default: cfg.half_width = 15'($urandom_range(0, 2000));
            endcase
            load_view(cfg);
            phase_len = $urandom_range(40, 150);
            // some phases run back to back with no gaps at all
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && rand_nonaux < RAND_ITEMS; k++) begin
                aux  = ($urandom_range(0, 7) == 0);
                // mostly present objects, some absent with random low bits
                if ($urandom_range(0, 7) == 0)
                    zone = 16'h8000 | 16'($urandom);
                else
                    zone = 16'($urandom_range(0, 16'h7FFF));
                // half near the viewer so the cull goes both ways, half anywhere
                if ($urandom_range(0, 1) == 0) begin
                    off_x = int'($urandom_range(0, 4095)) - 2048;
                    off_z = int'($urandom_range(0, 4095)) - 2048;
                    px    = view_regs.viewer_x + 16'(off_x);
                    pz    = view_regs.viewer_z + 16'(off_z);
                end else begin
                    px = 16'($urandom);
                    pz = 16'($urandom);
                end
                last = ($urandom_range(0, 9) == 0);
                send_item(aux, zone, px, pz, last, quiet ? 0 : $urandom_range(0, 7),
                          1'b0, '0);
                if (!aux)
                    rand_nonaux++;
            end
        end

        // drain and let the pipe run empty before the verdict
        start <= 1'b0;
        wait_drained();

        $display("run covered %0d items (%0d auxiliary, %0d absent) over %0d view settings",
                 items_sent, aux_sent, absent_sent, settings_loaded);
        $display("%0d results compared, %0d in line, %0d mismatches",
                 results_checked, in_line_seen, mismatch_count);
        if (mismatch_count == 0 && cull_results_due.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/vsil_pkg.sv
design/vsil_regs.sv
design/vsil_delta.sv
design/vsil_mult.sv
design/vsil_accum.sv
design/vsil_cull.sv
design/view_space_in_line_test.sv
test/tb_top.sv
